### sv/crc16_pkg.sv
// Package for the CRC-16 byte stream block: constants, the item type and the
// byte-wide CRC fold function.
// No dependencies; used by every module of the block.
package crc16_pkg;

	localparam logic [15:0] CRC_POLY     = 16'h8005;
	localparam logic [15:0] CRC_OUT_XOR  = 16'h00D8;
	localparam logic [15:0] CRC_INIT_RST = 16'h0678;

	// One message byte and its end-of-message mark
	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} crc16_item_t;

	// Fold one byte into the remainder, most significant bit first
	function automatic logic [15:0] crc16_fold(input logic [15:0] rem, input logic [7:0] byte_in);
		logic [15:0] r;
		r = rem ^ {byte_in, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

### sv/crc16_in_reg.sv
// Input register of the CRC-16 byte stream block: holds one accepted byte.
// Depends on crc16_pkg.
module crc16_in_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  crc16_pkg::crc16_item_t in_item,
	input  logic                  advance,
	output logic                  item_valid_s1,
	output crc16_pkg::crc16_item_t item_s1
);
	import crc16_pkg::*;

	// Take a new byte when the stage is empty or its byte moves on this cycle
	assign in_ready = !item_valid_s1 || advance;

	// Hold stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	// Capture the byte on each transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

### sv/crc16_update.sv
// Remainder update and result register of the CRC-16 byte stream block.
// Depends on crc16_pkg.
module crc16_update (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid_s1,
	input  crc16_pkg::crc16_item_t item_s1,
	input  logic [15:0]           init_value,
	output logic                  advance,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [15:0]           out_crc
);
	import crc16_pkg::*;

	logic [15:0] rem_q;
	logic        start_q;
	logic [15:0] rem_base;
	logic [15:0] rem_next;
	logic [15:0] crc_s2;
	logic        out_valid_s2;

	// Fold the staged byte into the running remainder, reloading at message start
	assign rem_base = start_q ? init_value : rem_q;
	assign rem_next = crc16_fold(rem_base, item_s1.data);

	// Move a byte on unless it ends a message and the result slot is full and not taken this cycle
	assign advance = item_valid_s1 && (!item_s1.last || !out_valid_s2 || out_ready);

	// Advance remainder, message-start flag and result occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q        <= 16'h0000;
			start_q      <= 1'b1;
			out_valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				rem_q   <= rem_next;
				start_q <= item_s1.last;
			end
			if (advance && item_s1.last) begin
				out_valid_s2 <= 1'b1;
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	// Load the finished CRC into the result register
	always_ff @(posedge clk) begin
		if (advance && item_s1.last) begin
			crc_s2 <= rem_next ^ CRC_OUT_XOR;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_crc   = crc_s2;

endmodule

### sv/crc16_byte_stream.sv
// Top level of the CRC-16 byte stream block: ports, init register, assertions.
// Depends on crc16_pkg, crc16_in_reg and crc16_update.

// CRC-16 (polynomial 0x8005, MSB first, no reflection) over byte messages.
// One byte is accepted every clock cycle when not stalled; the rate is set
// by the byte-wide remainder fold between the input and remainder registers.
// The input stalls only while a tlast byte sits in the input register and the
// result register still holds an earlier CRC that is not taken this cycle.
// The CRC of a message (remainder XOR 0x00D8) goes to the result register
// when its tlast byte leaves the input register, later while that stall lasts.
// init_value (reset 0x0678) is loaded at the first byte of each message;
// write it only while the block is idle.
module crc16_byte_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] crc_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // [15:0] init_value
);
	import crc16_pkg::*;

	logic [15:0] init_q;
	crc16_item_t in_item;
	crc16_item_t item_s1;
	logic        item_valid_s1;
	logic        advance;

	// Always take configuration transfers
	assign cfg_ready = 1'b1;

	// Hold the initial remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= CRC_INIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			init_q <= cfg_data;
		end
	end

	assign in_item.data = s_tdata;
	assign in_item.last = s_tlast;

	crc16_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_item       (in_item),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	crc16_update u_update (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.init_value    (init_q),
		.advance       (advance),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_crc       (m_tdata)
	);

	// A new result appears only after a last byte was folded
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(advance && item_s1.last))
		else $error("result raised without a folded last byte");

	// Input stalls only while the stage holds a byte that cannot move
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (item_valid_s1 && !advance))
		else $error("input stalled with no blocked byte");

	// Never overwrite a pending result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && item_s1.last && m_tvalid && !m_tready))
		else $error("pending result overwritten");

endmodule
